@@ rtl/core/toy_risc_execute_unit_defines.svh @@
// assertion macros shared by the execute unit rtl
`ifndef TOY_RISC_EXECUTE_UNIT_DEFINES_SVH
`define TOY_RISC_EXECUTE_UNIT_DEFINES_SVH

// same-cycle check, clocked on i_clk, off while i_rst_n is low
`define TRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, clocked on i_clk, off while i_rst_n is low
`define TRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tre_pkg.sv @@
// types, codes and helpers shared by the execute unit
`timescale 1ns / 1ps

package tre_pkg;

    // opcodes, bits 31..24 of the instruction word
    localparam logic [7:0] OP_ADD = 8'd0;
    localparam logic [7:0] OP_SUB = 8'd1;
    localparam logic [7:0] OP_AND = 8'd2;
    localparam logic [7:0] OP_MOV = 8'd3;
    localparam logic [7:0] OP_MVN = 8'd4;
    localparam logic [7:0] OP_B   = 8'd5;
    localparam logic [7:0] OP_LDR = 8'd6;
    localparam logic [7:0] OP_STR = 8'd7;
    localparam logic [7:0] OP_SVC = 8'd8;

    // supervisor call codes, carried in the rm field
    localparam logic [7:0] SVC_GETC = 8'h25;
    localparam logic [7:0] SVC_PUTC = 8'h22;
    localparam logic [7:0] SVC_HALT = 8'h27;

    // branch conditions, bits 31..28
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_AL = 4'hE;

    // register indexes
    localparam logic [7:0] REG_R0    = 8'd0;
    localparam logic [7:0] REG_PC    = 8'd8;
    localparam logic [7:0] REG_FLAGS = 8'd9;
    localparam logic [7:0] NUM_REGS  = 8'd10;

    // fault codes
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_OPCODE = 2'd1;
    localparam logic [1:0] FAULT_SVC    = 2'd2;
    localparam logic [1:0] FAULT_REG    = 2'd3;

    localparam logic [31:0] START_PC_RST = 32'h0000_3000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_MUL,
        ST_RED,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [1:0]  fault;
        logic        halted;
        logic [7:0]  char_out;
        logic        char_valid;
        logic [31:0] pc_value;
    } t_result;

    typedef struct packed {
        logic        reg_we;
        logic [3:0]  reg_idx;
        logic [31:0] reg_data;
        logic        flags_we;
        logic        flag_z;
        logic        flag_n;
        logic        stop_set;
        logic        ld;
        logic        st;
        logic [31:0] mem_sum;
        logic [31:0] mem_data;
    } t_update;

    // second register read: rd for a store, R0 for a supervisor call, else rm
    function automatic logic [7:0] port_b_idx(input logic [31:0] ins);
        logic [7:0] idx;
        begin
            if (ins[31:24] == OP_STR) begin
                idx = ins[23:16];
            end else if (ins[31:24] == OP_SVC) begin
                idx = REG_R0;
            end else begin
                idx = ins[7:0];
            end
            return idx;
        end
    endfunction

endpackage

@@ rtl/core/tre_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tre_addr.sv @@
// data memory address reduction modulo the memory depth
`timescale 1ns / 1ps

module tre_addr #(
    parameter int MEM_WORDS = 4096,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  logic          i_clk,
    input  logic [31:0]   i_sum,
    input  logic          i_cap_sum,
    input  logic          i_cap_addr,
    output logic [AW-1:0] o_addr_fast,
    output logic [AW-1:0] o_addr_slow
);

    // quotient estimate from a truncated reciprocal is low by at most one
    localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / MEM_WORDS;
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [31:0] M32     = 32'(MEM_WORDS);
    localparam logic [AW:0] M_EXT   = (AW + 1)'(MEM_WORDS);

    logic [31:0] r_sum;
    logic [63:0] r_prod;
    logic [AW-1:0] r_addr;
    logic [31:0] qm;
    logic [31:0] rem32;
    logic [AW:0] rem;
    logic [AW:0] n_addr;

    // power-of-two depth: plain mask
    assign o_addr_fast = i_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cap_sum) begin
            r_sum  <= i_sum;
            r_prod <= {32'b0, i_sum} * {32'b0, RECIP};
        end
        if (i_cap_addr) begin
            r_addr <= n_addr[AW-1:0];
        end
    end

    always_comb begin
        qm    = r_prod[63:32] * M32;
        rem32 = r_sum - qm;
        rem   = rem32[AW:0];
        if (rem >= M_EXT) begin
            n_addr = rem - M_EXT;
        end else begin
            n_addr = rem;
        end
    end

    assign o_addr_slow = r_addr;

endmodule

@@ rtl/core/tre_exec.sv @@
// decode and execute of one instruction word
`timescale 1ns / 1ps

module tre_exec (
    input  logic [31:0]       i_ins,
    input  logic [7:0]        i_key,
    input  logic [31:0]       i_opa,
    input  logic [31:0]       i_opb,
    input  logic [31:0]       i_pc,
    input  logic              i_flag_z,
    input  logic              i_stopped,
    input  logic [31:0]       i_ld_data,
    output tre_pkg::t_update  o_upd,
    output tre_pkg::t_result  o_res
);

    import tre_pkg::*;

    logic [7:0]  op;
    logic [7:0]  rd;
    logic [7:0]  rn;
    logic [7:0]  rm;
    logic [3:0]  cond;
    logic        bad;
    logic        live;
    logic        wr;
    logic        branch;
    logic [31:0] value;
    logic [31:0] off4;
    logic [31:0] pc_base;
    logic [31:0] pc_next;
    logic [1:0]  fault;
    logic        cvalid;
    logic        halt;

    assign op   = i_ins[31:24];
    assign rd   = i_ins[23:16];
    assign rn   = i_ins[15:8];
    assign rm   = i_ins[7:0];
    assign cond = i_ins[31:28];
    assign off4 = {{6{i_ins[23]}}, i_ins[23:0], 2'b00};

    always_comb begin
        // index check only on the fields the opcode uses
        case (op)
            OP_ADD, OP_SUB, OP_AND: bad = (rd >= NUM_REGS) || (rn >= NUM_REGS) ||
                                          (rm >= NUM_REGS);
            OP_MOV:                 bad = (rd >= NUM_REGS);
            OP_MVN:                 bad = (rd >= NUM_REGS) || (rm >= NUM_REGS);
            OP_LDR, OP_STR:         bad = (rd >= NUM_REGS) || (rn >= NUM_REGS);
            default:                bad = 1'b0;
        endcase

        case (op)
            OP_ADD:  value = i_opa + i_opb;
            OP_SUB:  value = i_opa - i_opb;
            OP_AND:  value = i_opa & i_opb;
            OP_MOV:  value = {16'b0, i_ins[15:0]};
            OP_MVN:  value = ~i_opb;
            OP_LDR:  value = i_ld_data;
            default: value = 32'b0;
        endcase

        live   = !i_stopped && !bad;
        wr     = live && (op == OP_ADD || op == OP_SUB || op == OP_AND ||
                          op == OP_MOV || op == OP_MVN || op == OP_LDR);
        branch = live && (op == OP_B) &&
                 ((cond == COND_AL) || ((cond == COND_EQ) && i_flag_z));

        fault  = FAULT_NONE;
        cvalid = 1'b0;
        halt   = 1'b0;
        if (!i_stopped) begin
            if (bad) begin
                fault = FAULT_REG;
            end else if (op == OP_SVC) begin
                if (rm == SVC_PUTC) begin
                    cvalid = 1'b1;
                end else if (rm == SVC_HALT) begin
                    halt = 1'b1;
                end else if (rm != SVC_GETC) begin
                    fault = FAULT_SVC;
                end
            end else if (op > OP_SVC) begin
                fault = FAULT_OPCODE;
            end
        end

        // a write to the pc lands before the usual advance
        if (wr && (rd == REG_PC)) begin
            pc_base = value;
        end else if (branch) begin
            pc_base = i_pc + off4;
        end else begin
            pc_base = i_pc;
        end
        pc_next = i_stopped ? i_pc : pc_base + 32'd4;

        o_upd          = '0;
        o_upd.flags_we = wr;
        o_upd.flag_z   = (value == 32'b0);
        o_upd.flag_n   = value[31];
        o_upd.stop_set = halt;
        o_upd.ld       = live && (op == OP_LDR);
        o_upd.st       = live && (op == OP_STR);
        o_upd.mem_sum  = i_opa + {20'b0, i_ins[11:0]};
        o_upd.mem_data = i_opb;
        if (wr) begin
            o_upd.reg_we   = 1'b1;
            o_upd.reg_idx  = rd[3:0];
            o_upd.reg_data = value;
        end else if (live && (op == OP_SVC) && (rm == SVC_GETC)) begin
            o_upd.reg_we   = 1'b1;
            o_upd.reg_idx  = REG_R0[3:0];
            o_upd.reg_data = {24'b0, i_key};
        end

        o_res.pc_value   = pc_next;
        o_res.char_valid = cvalid;
        o_res.char_out   = cvalid ? i_opb[7:0] : 8'b0;
        o_res.halted     = i_stopped || halt;
        o_res.fault      = fault;
    end

endmodule

@@ rtl/core/toy_risc_execute_unit.sv @@
// top level of the toy register machine execute unit
// usage:
// - instructions come in on the s_axis channel, one instruction word and one key
//   character per transfer; each one gives exactly one result transfer on m_axis
//   (pc after the instruction, character out, halted flag and fault code)
// - start_pc is written through the cfg channel, which is always ready; the write
//   loads the pc at once and must only happen while the unit is idle
// - an accepted instruction waits in the input register until its result is loaded
//   into the output register, which happens once the output register has room and
//   any memory access is done; output valid is driven from the output register
// - throughput is one instruction per cycle while the receiver keeps up; a load waits
//   in the load state since the data memory has a registered read port; with a depth
//   not a power of two, loads and stores also go through the modulo reduction states
// - r0..r7 live in two mirrored 8-entry rams read when the instruction is
//   accepted, with a bypass for the write retiring on that same edge; pc and flags
//   are flops
// - after reset the data memory is cleared one word a cycle, all MEM_WORDS words,
//   during which s_axis_tready stays low
// - when the receiver stalls, the finished result holds in the output register and
//   one more instruction can wait in the input register before tready drops
`timescale 1ns / 1ps
`include "toy_risc_execute_unit_defines.svh"

module toy_risc_execute_unit #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // instruction stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // instruction[31:0], key_char[39:32]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pc_value[31:0], char_valid[32], char_out[40:33], halted[41], fault[43:42]
    output logic [47:0] o_m_axis_tdata,
    // start_pc write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    import tre_pkg::*;

    localparam int            AW       = $clog2(MEM_WORDS);
    localparam bit            POW2     = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

    // control state
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr;
    logic          r_in_valid;
    logic          r_out_valid;
    logic [31:0]   r_pc;
    logic          r_flag_z;
    logic          r_flag_n;
    logic          r_stopped;
    logic [7:0]    r_vld;          // register file entries written since reset

    // payload
    logic [31:0]   r_ins;
    logic [7:0]    r_key;
    t_result       r_out_res;
    logic          r_hit_a;
    logic          r_hit_b;
    logic          r_va;
    logic          r_vb;
    logic [31:0]   r_byp;

    // datapath
    logic          s_acc;
    logic          cfg_acc;
    logic          out_free;
    logic          exec_fire;
    logic          mem_re;
    logic          clr_we;
    logic          cap_sum;
    logic          cap_addr;
    logic          rf_we;
    logic [7:0]    in_idx_a;
    logic [7:0]    in_idx_b;
    logic [31:0]   rf_rdata_a;
    logic [31:0]   rf_rdata_b;
    logic [31:0]   opa;
    logic [31:0]   opb;
    logic [31:0]   flags_word;
    logic [31:0]   mem_rdata;
    logic [AW-1:0] addr_fast;
    logic [AW-1:0] addr_slow;
    logic [AW-1:0] mem_addr;
    t_update       upd;
    t_result       res;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_idx_a = i_s_axis_tdata[15:8];
    assign in_idx_b = port_b_idx(i_s_axis_tdata[31:0]);

    assign o_s_axis_tready = (r_state != ST_CLEAR) && (!r_in_valid || exec_fire);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out_res.fault, r_out_res.halted,
                              r_out_res.char_out, r_out_res.char_valid,
                              r_out_res.pc_value};

    // ---------------- sequencing ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        exec_fire = 1'b0;
        mem_re    = 1'b0;
        clr_we    = 1'b0;
        cap_sum   = 1'b0;
        cap_addr  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_in_valid) begin
                    if (upd.ld || upd.st) begin
                        if (POW2) begin
                            if (upd.ld) begin
                                mem_re  = 1'b1;
                                n_state = ST_LOAD;
                            end else if (out_free) begin
                                exec_fire = 1'b1;
                            end
                        end else begin
                            cap_sum = 1'b1;
                            n_state = ST_MUL;
                        end
                    end else if (out_free) begin
                        exec_fire = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                cap_addr = 1'b1;
                n_state  = ST_RED;
            end
            ST_RED: begin
                if (upd.ld) begin
                    mem_re  = 1'b1;
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    exec_fire = 1'b1;
                    n_state   = ST_RUN;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    exec_fire = 1'b1;
                    n_state   = ST_RUN;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // register reads happen on the accept edge; catch the write retiring there
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ins   <= i_s_axis_tdata[31:0];
            r_key   <= i_s_axis_tdata[39:32];
            r_hit_a <= rf_we && (upd.reg_idx[2:0] == in_idx_a[2:0]);
            r_hit_b <= rf_we && (upd.reg_idx[2:0] == in_idx_b[2:0]);
            r_va    <= r_vld[in_idx_a[2:0]];
            r_vb    <= r_vld[in_idx_b[2:0]];
            r_byp   <= upd.reg_data;
        end
    end

    // ---------------- register file ----------------
    assign rf_we = exec_fire && upd.reg_we && !upd.reg_idx[3];

    tre_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (upd.reg_idx[2:0]),
        .i_wdata (upd.reg_data),
        .i_re    (s_acc),
        .i_raddr (in_idx_a[2:0]),
        .o_rdata (rf_rdata_a)
    );

    tre_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (upd.reg_idx[2:0]),
        .i_wdata (upd.reg_data),
        .i_re    (s_acc),
        .i_raddr (in_idx_b[2:0]),
        .o_rdata (rf_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (rf_we) begin
            r_vld[upd.reg_idx[2:0]] <= 1'b1;
        end
    end

    // pc and flags read straight from their flops, r0..r7 from ram or bypass, or zero before their first write
    function automatic logic [31:0] f_operand(
        input logic [7:0]  idx,
        input logic [31:0] ram,
        input logic        hit,
        input logic        vld,
        input logic [31:0] byp,
        input logic [31:0] pc,
        input logic [31:0] flg
    );
        logic [31:0] val;
        begin
            if (idx == REG_PC) begin
                val = pc;
            end else if (idx == REG_FLAGS) begin
                val = flg;
            end else if (hit) begin
                val = byp;
            end else if (vld) begin
                val = ram;
            end else begin
                val = 32'b0;
            end
            return val;
        end
    endfunction

    assign flags_word = {r_flag_n, r_flag_z, 30'b0};
    assign opa = f_operand(r_ins[15:8], rf_rdata_a, r_hit_a, r_va, r_byp, r_pc, flags_word);
    assign opb = f_operand(port_b_idx(r_ins), rf_rdata_b, r_hit_b, r_vb, r_byp, r_pc,
                           flags_word);

    // ---------------- execute ----------------
    tre_exec u_exec (
        .i_ins     (r_ins),
        .i_key     (r_key),
        .i_opa     (opa),
        .i_opb     (opb),
        .i_pc      (r_pc),
        .i_flag_z  (r_flag_z),
        .i_stopped (r_stopped),
        .i_ld_data (mem_rdata),
        .o_upd     (upd),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= START_PC_RST;
            r_flag_z  <= 1'b1;
            r_flag_n  <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_pc <= i_cfg_data;
            end else if (exec_fire) begin
                r_pc <= res.pc_value;
            end
            if (exec_fire && upd.flags_we) begin
                r_flag_z <= upd.flag_z;
                r_flag_n <= upd.flag_n;
            end
            if (exec_fire && upd.stop_set) begin
                r_stopped <= 1'b1;
            end
        end
    end

    // ---------------- data memory ----------------
    tre_addr #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_addr (
        .i_clk       (i_clk),
        .i_sum       (upd.mem_sum),
        .i_cap_sum   (cap_sum),
        .i_cap_addr  (cap_addr),
        .o_addr_fast (addr_fast),
        .o_addr_slow (addr_slow)
    );

    assign mem_addr = POW2 ? addr_fast : addr_slow;

    tre_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (clr_we || (exec_fire && upd.st)),
        .i_waddr (clr_we ? r_clr : mem_addr),
        .i_wdata (clr_we ? 32'b0 : upd.mem_data),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_res <= res;
        end
    end

    // ---------------- checks ----------------
    `TRE_ASSERT_NOW(a_no_accept_in_clear, r_state == ST_CLEAR, !o_s_axis_tready && !rf_we,
        "instruction taken or register written while memory clears")
    `TRE_ASSERT_NOW(a_load_state, r_state == ST_LOAD, r_in_valid && upd.ld,
        "load wait state without a load in the input register")
    `TRE_ASSERT_NEXT(a_halt_holds_pc, r_stopped && !cfg_acc, $stable(r_pc),
        "pc moved after halt")
    `TRE_ASSERT_NOW(a_fire_needs_room, exec_fire, r_in_valid && out_free,
        "result produced with no instruction or no output room")

endmodule

@@ dv/toy_risc_execute_unit_test.sv @@
// self-checking testbench for the toy register machine execute unit
`timescale 1ns / 1ps

module toy_risc_execute_unit_test;

    import tre_pkg::*;

    localparam int          MEM_WORDS     = 4096;
    localparam logic [31:0] MEM_DEPTH     = 32'(MEM_WORDS);
    localparam logic [31:0] FLAG_Z        = 32'h4000_0000;
    localparam logic [31:0] FLAG_N        = 32'h8000_0000;
    localparam int          RESET_CYCLES  = 5;
    localparam int          RANDOM_ITEMS  = 1650;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          WATCHDOG_NS   = 2_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    logic [39:0] src_data  = '0;
    logic        snk_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_ready;
    logic        m_valid;
    logic [47:0] m_data;
    logic        cfg_ready;

    // idling controls for both sides
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit snk_hold    = 1'b0;
    int snk_wait    = 0;
    int snk_gap;

    // machine copy used for prediction
    logic [31:0] start_pc_reg;
    logic [31:0] arch_regs [0:9];
    logic [31:0] data_words [0:MEM_WORDS-1];
    bit          machine_stopped;

    t_result expected_results [$];
    t_result got;
    t_result want;
    int      fail_count     = 0;
    int      items_sent     = 0;
    int      results_seen   = 0;
    int      start_pc_loads = 0;

    toy_risc_execute_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(src_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (src_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(snk_ready),
        .o_m_axis_tdata (m_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- machine copy

    function automatic void write_back(input logic [7:0] idx, input logic [31:0] value);
        arch_regs[idx] = value;
        if (value == 32'd0) begin
            arch_regs[REG_FLAGS] = FLAG_Z;
        end else if (value[31]) begin
            arch_regs[REG_FLAGS] = FLAG_N;
        end else begin
            arch_regs[REG_FLAGS] = 32'd0;
        end
    endfunction

    function automatic t_result execute_instruction(input logic [31:0] ins,
                                                    input logic [7:0] key);
        logic [7:0]  op;
        logic [7:0]  rd;
        logic [7:0]  rn;
        logic [7:0]  rm;
        logic [31:0] offset;
        logic [31:0] addr;
        logic        bad_reg;
        t_result     res;
        op  = ins[31:24];
        rd  = ins[23:16];
        rn  = ins[15:8];
        rm  = ins[7:0];
        res = '0;
        if (!machine_stopped) begin
            // only the fields an opcode actually uses are range checked
            case (op)
                OP_ADD, OP_SUB, OP_AND:
                    bad_reg = rd >= NUM_REGS || rn >= NUM_REGS || rm >= NUM_REGS;
                OP_MOV:
                    bad_reg = rd >= NUM_REGS;
                OP_MVN:
                    bad_reg = rd >= NUM_REGS || rm >= NUM_REGS;
                OP_LDR, OP_STR:
                    bad_reg = rd >= NUM_REGS || rn >= NUM_REGS;
                default:
                    bad_reg = 1'b0;
            endcase
            if (bad_reg) begin
                res.fault = FAULT_REG;
            end else begin
                case (op)
                    OP_ADD: write_back(rd, arch_regs[rn] + arch_regs[rm]);
                    OP_SUB: write_back(rd, arch_regs[rn] - arch_regs[rm]);
                    OP_AND: write_back(rd, arch_regs[rn] & arch_regs[rm]);
                    OP_MOV: write_back(rd, {16'd0, ins[15:0]});
                    OP_MVN: write_back(rd, ~arch_regs[rm]);
                    OP_B: begin
                        offset = {{8{ins[23]}}, ins[23:0]};
                        if (ins[31:28] == COND_AL ||
                            (ins[31:28] == COND_EQ && (arch_regs[REG_FLAGS] & FLAG_Z) != 0)) begin
                            arch_regs[REG_PC] = arch_regs[REG_PC] + (offset << 2);
                        end
                    end
                    OP_LDR: begin
                        addr = (arch_regs[rn] + {20'd0, ins[11:0]}) % MEM_DEPTH;
                        write_back(rd, data_words[addr]);
                    end
                    OP_STR: begin
                        addr = (arch_regs[rn] + {20'd0, ins[11:0]}) % MEM_DEPTH;
                        data_words[addr] = arch_regs[rd];
                    end
                    OP_SVC: begin
                        if (rm == SVC_GETC) begin
                            arch_regs[REG_R0] = {24'd0, key};
                        end else if (rm == SVC_PUTC) begin
                            res.char_valid = 1'b1;
                            res.char_out   = arch_regs[REG_R0][7:0];
                        end else if (rm == SVC_HALT) begin
                            machine_stopped = 1'b1;
                        end else begin
                            res.fault = FAULT_SVC;
                        end
                    end
                    default: res.fault = FAULT_OPCODE;
                endcase
            end
            arch_regs[REG_PC] = arch_regs[REG_PC] + 32'd4;
        end
        res.pc_value = arch_regs[REG_PC];
        res.halted   = machine_stopped;
        return res;
    endfunction

    initial begin
        start_pc_reg = START_PC_RST;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (data_words[i]) data_words[i] = '0;
        arch_regs[REG_PC]    = START_PC_RST;
        arch_regs[REG_FLAGS] = FLAG_Z;
        machine_stopped      = 1'b0;
    end

    // ---------------------------------------------------------------- encoders

    function automatic logic [31:0] encode(input logic [7:0] op, input logic [7:0] rd,
                                           input logic [7:0] rn, input logic [7:0] rm);
        return {op, rd, rn, rm};
    endfunction

    function automatic logic [31:0] mov_imm(input logic [7:0] rd, input logic [15:0] imm);
        return {OP_MOV, rd, imm};
    endfunction

    function automatic logic [31:0] branch(input logic [23:0] offset);
        return {OP_B, offset};
    endfunction

    // mostly in range, now and then a bad index
    function automatic logic [7:0] pick_reg();
        if ($urandom_range(0, 99) < 94) begin
            return 8'($urandom_range(0, 9));
        end
        return 8'($urandom_range(10, 255));
    endfunction

    function automatic logic [31:0] random_instruction(input bit allow_halt);
        int          pick;
        int          flavor;
        logic [7:0]  op;
        logic [7:0]  code;
        logic [15:0] imm;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            flavor = $urandom_range(0, 3);
            op = (flavor == 0) ? OP_ADD : (flavor == 1) ? OP_SUB :
                 (flavor == 2) ? OP_AND : OP_MVN;
            word = encode(op, pick_reg(), pick_reg(), pick_reg());
        end else if (pick < 62) begin
            flavor = $urandom_range(0, 9);
            if (flavor < 5) begin
                imm = 16'($urandom_range(0, 15));
            end else if (flavor < 7) begin
                imm = (flavor == 5) ? 16'hFFFF : 16'h8000;
            end else begin
                imm = 16'($urandom);
            end
            word = mov_imm(pick_reg(), imm);
        end else if (pick < 67) begin
            if ($urandom_range(0, 3) != 0) begin
                word = branch(24'($signed($urandom_range(0, 16)) - 8));
            end else begin
                word = branch(24'($urandom));
            end
        end else if (pick < 82) begin
            // low byte kept small so stores and loads meet the same words
            op = ($urandom_range(0, 1) != 0) ? OP_LDR : OP_STR;
            code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) :
                                                  8'($urandom_range(0, 255));
            word = encode(op, pick_reg(), pick_reg(), code);
        end else if (pick < 92) begin
            flavor = $urandom_range(0, 9);
            if (flavor < 4) begin
                code = SVC_GETC;
            end else if (flavor < 8) begin
                code = SVC_PUTC;
            end else begin
                code = 8'($urandom_range(0, 255));
            end
            word = encode(OP_SVC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          code);
        end else begin
            word = $urandom;
        end
        // a halt would freeze the machine for the rest of the run
        if (!allow_halt && word[31:24] == OP_SVC && word[7:0] == SVC_HALT) begin
            word[0] = ~word[0];
        end
        return word;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input logic [31:0] ins, input logic [7:0] key);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= {key, ins};
        do @(posedge clk); while (!s_ready);
        expected_results.push_back(execute_instruction(ins, key));
        items_sent++;
    endtask

    task automatic wait_for_results();
        int guard;
        src_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_pc(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_pc_reg      = value;
        arch_regs[REG_PC] = start_pc_reg;
        start_pc_loads++;
    endtask

    // receiver: a random pause before each transfer, or a long hold when asked
    always @(posedge clk) begin
        if (!rst_n) begin
            snk_ready <= 1'b0;
            snk_wait  <= 0;
        end else if (snk_hold) begin
            snk_ready <= 1'b0;
        end else if (snk_ready && m_valid) begin
            snk_gap = snk_idle_on ? $urandom_range(0, 10) : 0;
            if (snk_gap != 0) begin
                snk_ready <= 1'b0;
                snk_wait  <= snk_gap;
            end
        end else if (!snk_ready) begin
            if (snk_wait <= 1) begin
                snk_ready <= 1'b1;
            end else begin
                snk_wait <= snk_wait - 1;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && m_valid && snk_ready) begin
            got = m_data[43:0];
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing pending, pc_value %h", got.pc_value);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.pc_value !== want.pc_value) begin
                    $error("pc_value expected %h actual %h", want.pc_value, got.pc_value);
                    fail_count++;
                end
                if (got.char_valid !== want.char_valid) begin
                    $error("char_valid expected %b actual %b", want.char_valid, got.char_valid);
                    fail_count++;
                end
                if (got.char_out !== want.char_out) begin
                    $error("char_out expected %h actual %h", want.char_out, got.char_out);
                    fail_count++;
                end
                if (got.halted !== want.halted) begin
                    $error("halted expected %b actual %b", want.halted, got.halted);
                    fail_count++;
                end
                if (got.fault !== want.fault) begin
                    $error("fault expected %0d actual %0d", want.fault, got.fault);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // runs under the reset start_pc, right after the memory clear
    task automatic test_directed_cases();
        send_item(mov_imm(8'd1, 16'hFFFF), 8'h00);
        send_item(mov_imm(8'd2, 16'h0000), 8'h00);
        send_item(encode(OP_SUB, 8'd3, 8'd2, 8'd1), 8'h00);       // negative result
        send_item(encode(OP_ADD, 8'd4, 8'd3, 8'd1), 8'h00);       // wraps to zero
        send_item(encode(OP_MVN, 8'd5, 8'd200, 8'd2), 8'h00);     // rn unused, no fault
        send_item(encode(OP_AND, 8'd6, 8'd5, 8'd1), 8'h00);
        send_item(encode(OP_ADD, 8'd7, 8'd5, 8'd5), 8'h00);
        send_item(mov_imm(8'd0, 16'h0000), 8'h00);                // sets Z
        send_item(branch(24'hFFFFFF), 8'h00);                     // taken, backwards
        send_item(branch(24'h7FFFFF), 8'h00);                     // taken, farthest forward
        send_item(mov_imm(8'd0, 16'h0001), 8'h00);                // clears Z
        send_item(branch(24'h800000), 8'h00);                     // not taken
        send_item(encode(OP_STR, 8'd1, 8'd5, 8'hFF), 8'h00);      // address wraps
        send_item(encode(OP_LDR, 8'd3, 8'd5, 8'hFF), 8'h00);
        send_item(encode(OP_SVC, 8'hFF, 8'hFF, SVC_GETC), 8'hFF);
        send_item(encode(OP_SVC, 8'h00, 8'h00, SVC_PUTC), 8'h00);
        send_item(encode(OP_SVC, 8'h00, 8'h00, 8'hFF), 8'h00);    // unsupported call
        send_item(encode(8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF);     // invalid opcodes
        send_item(encode(8'h09, 8'd0, 8'd0, 8'd0), 8'h00);
        send_item(encode(OP_ADD, 8'd10, 8'd0, 8'd0), 8'h00);      // bad register indexes
        send_item(encode(OP_SUB, 8'd0, 8'd0, 8'd255), 8'h00);
        send_item(encode(OP_LDR, 8'd0, 8'd10, 8'd0), 8'h00);
        send_item(encode(OP_STR, 8'd10, 8'd0, 8'd0), 8'h00);
        send_item(encode(OP_MVN, 8'd0, 8'd0, 8'd10), 8'h00);
        send_item(mov_imm(REG_PC, 16'h0100), 8'h00);              // write into pc
        send_item(mov_imm(REG_FLAGS, 16'h0005), 8'h00);           // flags overwritten
        wait_for_results();
    endtask

    task automatic test_start_pc_extremes();
        logic [31:0] settings [5];
        settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h7FFF_FFFC, $urandom};
        foreach (settings[i]) begin
            wait_for_results();
            write_start_pc(settings[i]);
            repeat (4) send_item(random_instruction(1'b0), 8'($urandom_range(0, 255)));
        end
        wait_for_results();
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_receiver_hold_off();
        src_idle_on = 1'b0;
        fork
            begin
                snk_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                snk_hold <= 1'b0;
            end
            repeat (16) send_item(random_instruction(1'b0), 8'($urandom_range(0, 255)));
        join
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_programs(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                src_idle_on = $urandom_range(0, 3) != 0;
                snk_idle_on <= $urandom_range(0, 3) != 0;
            end
            // sender pause until everything is back, then a new start_pc
            if (n % 350 == 349) begin
                wait_for_results();
                write_start_pc(($urandom_range(0, 1) != 0) ? $urandom : {$urandom} & ~32'd3);
            end
            send_item(random_instruction(1'b0), 8'($urandom_range(0, 255)));
        end
        wait_for_results();
    endtask

    // the halt freezes the machine, so it comes last
    task automatic test_halt();
        src_idle_on = 1'b1;
        snk_idle_on <= 1'b1;
        send_item(encode(OP_SVC, 8'd0, 8'd0, SVC_GETC), 8'h48);
        send_item(encode(OP_SVC, 8'd0, 8'd0, SVC_PUTC), 8'h00);
        send_item(encode(OP_SVC, 8'd0, 8'd0, SVC_HALT), 8'h00);
        repeat (30) send_item(random_instruction(1'b1), 8'($urandom_range(0, 255)));
        wait_for_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // memory clear after reset keeps tready low
        do @(posedge clk); while (!s_ready);
        test_directed_cases();
        test_start_pc_extremes();
        test_receiver_hold_off();
        test_random_programs(RANDOM_ITEMS);
        test_halt();
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("covered %0d instructions and %0d results over %0d start_pc loads,",
                 items_sent, results_seen, start_pc_loads);
        $display("with faults, wraps, branches, memory traffic, back-pressure and halt");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tre_pkg.sv
rtl/core/tre_ram.sv
rtl/core/tre_addr.sv
rtl/core/tre_exec.sv
rtl/core/toy_risc_execute_unit.sv
dv/toy_risc_execute_unit_test.sv
